/* hdl/matrix_multiply_4x4_macros.svh */
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MM4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MM4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mm4_pkg.sv */
package mm4_pkg;

    localparam int VALUE_W = 32;
    localparam int PROD_W  = 2 * VALUE_W;

    localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

/* hdl/mm4_ram.sv */
module mm4_ram
    import mm4_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mm4_mac.sv */
module mm4_mac
    import mm4_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctrl                 i_ctrl,
    input  logic signed [VALUE_W-1:0] i_a,
    input  logic signed [VALUE_W-1:0] i_b,
    output logic                      o_done,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam int ACC_W = PROD_W + $clog2(DIM);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctrl                r_mul_ctrl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_shifted;
    logic                     w_fits;

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ctrl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_mul_ctrl <= i_ctrl;
            r_done     <= r_mul_ctrl.vld & r_mul_ctrl.last;
        end
        r_prod <= i_a * i_b;
        if (r_mul_ctrl.vld) begin
            r_acc <= r_mul_ctrl.first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    // The exact sum is floored by the shift, then clamped to the 32-bit range.
    assign w_shifted = r_acc >>> FRAC_BITS;
    assign w_fits    = (&w_shifted[ACC_W-1:VALUE_W-1]) | ~(|w_shifted[ACC_W-1:VALUE_W-1]);
    assign o_value   = w_fits ? w_shifted[VALUE_W-1:0] : (r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX);
    assign o_done    = r_done;

endmodule

/* hdl/matrix_multiply_4x4.sv */
// Fixed-point DIM x DIM matrix multiplier, signed Q16.16 by default.
// Input channel (i_in_valid / o_in_ready): each word writes one element of the
// first or second matrix at a flat index; an index past the matrix is dropped.
// A word with compute_now set stores its element and then starts a product.
// Loads are taken one per cycle while no product is running.
// Output channel (o_out_valid / i_out_ready): a product streams DIM*DIM words
// in flat index order, the last one flagged. result[i][j] is the sum over k of
// first[k][j] * second[i][k], floored by FRAC_BITS and saturated to 32 bits.
// Each result element takes DIM reads of the two element memories (one read
// port each), then multiply, accumulate and hand-off; the reads for the next
// element start only after that hand-off.
// A stall on the output holds the finished word in the output register and
// pauses the sequencer; no word is lost. The input is not ready during a
// product. Reset clears the control state; the matrix memories keep their
// contents and must be loaded before the first product.
`include "matrix_multiply_4x4_macros.svh"

module matrix_multiply_4x4
    import mm4_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_operand_select,
    input  logic [$clog2(DIM*DIM)-1:0]             i_element_index,
    input  logic signed [VALUE_W-1:0]              i_element_value,
    input  logic                                   i_compute_now,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [$clog2(DIM*DIM)-1:0]             o_result_index,
    output logic signed [VALUE_W-1:0]              o_result_value,
    output logic                                   o_last_result
);

    localparam int CELLS = DIM * DIM;
    localparam int IDX_W = $clog2(CELLS);
    localparam int K_W   = $clog2(DIM);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [K_W-1:0]            r_row;
    logic [K_W-1:0]            r_col;
    logic [K_W-1:0]            r_k;
    t_mac_ctrl                 r_rd_ctrl;
    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_index;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_last;

    logic                      w_in_take;
    logic                      w_in_range;
    logic                      w_out_free;
    logic                      w_last_cell;
    logic [IDX_W-1:0]          w_first_raddr;
    logic [IDX_W-1:0]          w_second_raddr;
    logic signed [VALUE_W-1:0] w_first_rdata;
    logic signed [VALUE_W-1:0] w_second_rdata;
    logic                      w_mac_done;
    logic signed [VALUE_W-1:0] w_mac_value;

    assign o_in_ready     = (r_state == S_IDLE);
    assign w_in_take      = i_in_valid & o_in_ready;
    assign w_in_range     = {1'b0, i_element_index} < (IDX_W+1)'(CELLS);
    assign w_out_free     = ~r_out_valid | i_out_ready;
    assign w_last_cell    = (r_row == K_W'(DIM-1)) && (r_col == K_W'(DIM-1));
    assign w_first_raddr  = IDX_W'(r_k * DIM + r_col);
    assign w_second_raddr = IDX_W'(r_row * DIM + r_k);

    mm4_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (IDX_W)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_take & w_in_range & ~i_operand_select),
        .i_waddr (i_element_index),
        .i_wdata (i_element_value),
        .i_raddr (w_first_raddr),
        .o_rdata (w_first_rdata)
    );

    mm4_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (IDX_W)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_take & w_in_range & i_operand_select),
        .i_waddr (i_element_index),
        .i_wdata (i_element_value),
        .i_raddr (w_second_raddr),
        .o_rdata (w_second_rdata)
    );

    mm4_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_rd_ctrl),
        .i_a     (w_first_rdata),
        .i_b     (w_second_rdata),
        .o_done  (w_mac_done),
        .o_value (w_mac_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_rd_ctrl   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ctrl.vld   <= (r_state == S_ISSUE);
            r_rd_ctrl.first <= (r_k == '0);
            r_rd_ctrl.last  <= (r_k == K_W'(DIM-1));
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take && i_compute_now) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_k == K_W'(DIM-1)) begin
                        r_k     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (w_mac_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= IDX_W'(r_row * DIM + r_col);
                        r_out_value <= w_mac_value;
                        r_out_last  <= w_last_cell;
                        if (w_last_cell) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            if (r_col == K_W'(DIM-1)) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_value = r_out_value;
    assign o_last_result  = r_out_last;

    `MM4_ASSERT_SAME(a_done_while_waiting, i_clk, i_rst_n, w_mac_done, r_state == S_WAIT, "accumulation finished outside the wait state")
    `MM4_ASSERT_SAME(a_last_index, i_clk, i_rst_n, o_out_valid && o_last_result, o_result_index == IDX_W'(CELLS-1), "last word carries the wrong index")
    `MM4_ASSERT_NEXT(a_compute_starts, i_clk, i_rst_n, w_in_take && i_compute_now, r_state == S_ISSUE && r_row == '0 && r_col == '0, "compute word did not start a product at the first element")

endmodule
